/* sv/tdss_pkg.sv */
package tdss_pkg;

  // Item kinds carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SET  = 2'd1,
    OP_SCAN = 2'd2
  } op_t;

  typedef logic [7:0] seg_t;

  // One-hot scan positions, bit 0 is digit 1.
  localparam logic [2:0] SCAN_D1 = 3'b001;
  localparam logic [2:0] SCAN_D2 = 3'b010;
  localparam logic [2:0] SCAN_D3 = 3'b100;

  // Digit index codes for a single-digit set.
  localparam logic [1:0] IDX_D1 = 2'd1;
  localparam logic [1:0] IDX_D2 = 2'd2;
  localparam logic [1:0] IDX_D3 = 2'd3;

  localparam seg_t       DASH_PATTERN = 8'h40;
  localparam seg_t       POINT_BIT    = 8'h80;
  localparam logic [15:0] NUMBER_MAX  = 16'd999;

  // Segment patterns for numerals 0 to 9, bit 0 is segment a.
  localparam seg_t NUMERAL_TABLE [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  // Encodes a character code; unknown codes give a blank digit with no point.
  function automatic seg_t encode_char(input logic [7:0] code, input logic point);
    seg_t seg;
    logic known;
    known = 1'b1;
    seg   = '0;
    if (code <= 8'd9) begin
      seg = NUMERAL_TABLE[code[3:0]];
    end else if (code >= 8'h30 && code <= 8'h39) begin
      seg = NUMERAL_TABLE[4'(code - 8'h30)];
    end else begin
      case (code)
        8'h2D:   seg = 8'h40;  // dash
        8'h61:   seg = 8'h77;  // a
        8'h62:   seg = 8'h7C;  // b
        8'h63:   seg = 8'h58;  // c
        8'h64:   seg = 8'h5E;  // d
        8'h65:   seg = 8'h79;  // e
        8'h66:   seg = 8'h71;  // f
        8'h68:   seg = 8'h74;  // h
        8'h6C:   seg = 8'h38;  // l
        8'h6E:   seg = 8'h54;  // n
        8'h6F:   seg = 8'h5C;  // o
        8'h72:   seg = 8'h50;  // r
        8'h73:   seg = 8'h6D;  // s
        8'h74:   seg = 8'h78;  // t
        8'h76:   seg = 8'h3E;  // v
        default: known = 1'b0;
      endcase
    end
    if (known && point) begin
      seg = seg | POINT_BIT;
    end
    return seg;
  endfunction

endpackage

/* sv/three_digit_seven_segment_scanner_top.sv */
// Three-digit multiplexed seven-segment display scanner.
//
// Input channel (in_*): one item per handshake. in_tuser selects the kind of
// item: load a number, set one digit from a character code, or a scan tick.
// Output channel (out_*): one item per scan tick, carrying the segment lines
// of the current digit and a one-hot digit select. Loads and digit sets give
// no output item; they only update the three stored patterns.
//
// Order: an accepted item is held in the input register until it executes,
// and its effect then lands in the pattern, scan and output registers; a scan
// tick's output item passes through the input register, then the output one.
// Throughput: one item per cycle while no scan tick is stalled, set by the
// single decode stage between the input register and the output register.
//
// Reset clears all three patterns to blank and points the scan at digit 1.
// When the receiver stalls, the output register holds its item. Loads and
// digit sets keep flowing, since they produce nothing, but the next scan tick
// waits in the input register and holds back every item behind it.
module three_digit_seven_segment_scanner_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] number_value, [17:16] digit_index, [25:18] char_code,
  // [26] point_flag, [31:27] zero
  input  logic [31:0] in_tdata,
  // [1:0] opcode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] segment_lines, [10:8] digit_select, [15:11] zero
  output logic [15:0] out_tdata
);

  import tdss_pkg::*;

  // Input register.
  logic        s1_valid_r, s1_valid_nxt;
  logic [31:0] s1_data_r;
  logic [1:0]  s1_user_r;

  // State and output registers.
  seg_t        pat_r   [3];
  seg_t        pat_nxt [3];
  logic [2:0]  scan_pos_r, scan_pos_nxt;
  logic        out_valid_r, out_valid_nxt;
  seg_t        out_seg_r, out_seg_nxt;
  logic [2:0]  out_sel_r, out_sel_nxt;

  // Decoded fields of the held item.
  op_t         s1_op;
  logic [15:0] s1_num;
  logic [1:0]  s1_idx;
  logic [7:0]  s1_code;
  logic        s1_point;
  logic        s1_adv;
  logic        s1_fire;

  // Decimal split of a number up to 999.
  logic [9:0]  num10;
  logic [3:0]  hund;
  logic [9:0]  hund_base;
  logic [6:0]  rem100;
  logic [3:0]  tens;
  logic [6:0]  tens_base;
  logic [3:0]  units;
  seg_t        cur_pat;

  assign s1_op    = op_t'(s1_user_r);
  assign s1_num   = s1_data_r[15:0];
  assign s1_idx   = s1_data_r[17:16];
  assign s1_code  = s1_data_r[25:18];
  assign s1_point = s1_data_r[26];

  // Only a scan tick needs room in the output register.
  assign s1_adv    = (s1_op != OP_SCAN) || !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_sel_r, out_seg_r};

  // Input register control.
  always_comb begin
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata;
      s1_user_r <= in_tuser;
    end
  end

  // Hundreds, tens and units by parallel compares against constant steps.
  always_comb begin
    num10     = s1_num[9:0];
    hund      = '0;
    hund_base = '0;
    for (int k = 1; k <= 9; k++) begin
      if (num10 >= 10'(k * 100)) begin
        hund      = 4'(k);
        hund_base = 10'(k * 100);
      end
    end
    rem100    = 7'(num10 - hund_base);
    tens      = '0;
    tens_base = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem100 >= 7'(k * 10)) begin
        tens      = 4'(k);
        tens_base = 7'(k * 10);
      end
    end
    units = 4'(rem100 - tens_base);
  end

  // Pattern of the digit under the scan position.
  always_comb begin
    unique case (scan_pos_r)
      SCAN_D2: cur_pat = pat_r[1];
      SCAN_D3: cur_pat = pat_r[2];
      default: cur_pat = pat_r[0];
    endcase
  end

  // Item execution: pattern updates, scan advance and output load.
  always_comb begin
    pat_nxt       = pat_r;
    scan_pos_nxt  = scan_pos_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_seg_nxt   = out_seg_r;
    out_sel_nxt   = out_sel_r;
    if (s1_fire) begin
      unique case (s1_op)
        OP_LOAD: begin
          if (s1_num <= NUMBER_MAX) begin
            pat_nxt[0] = encode_char({4'b0, hund}, s1_point);
            pat_nxt[1] = encode_char({4'b0, tens}, s1_point);
            pat_nxt[2] = encode_char({4'b0, units}, s1_point);
          end else begin
            pat_nxt[0] = DASH_PATTERN;
            pat_nxt[1] = DASH_PATTERN;
            pat_nxt[2] = DASH_PATTERN;
          end
        end
        OP_SET: begin
          unique case (s1_idx)
            IDX_D1:  pat_nxt[0] = encode_char(s1_code, s1_point);
            IDX_D2:  pat_nxt[1] = encode_char(s1_code, s1_point);
            IDX_D3:  pat_nxt[2] = encode_char(s1_code, s1_point);
            default: ;
          endcase
        end
        OP_SCAN: begin
          out_valid_nxt = 1'b1;
          out_seg_nxt   = cur_pat;
          out_sel_nxt   = scan_pos_r;
          scan_pos_nxt  = {scan_pos_r[1:0], scan_pos_r[2]};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r[0]    <= '0;
      pat_r[1]    <= '0;
      pat_r[2]    <= '0;
      scan_pos_r  <= SCAN_D1;
      out_valid_r <= 1'b0;
    end else begin
      pat_r       <= pat_nxt;
      scan_pos_r  <= scan_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_seg_r <= out_seg_nxt;
    out_sel_r <= out_sel_nxt;
  end

  // The scan position always marks exactly one digit.
  assert property (@(posedge clk) disable iff (!rst_n) $onehot(scan_pos_r))
    else $error("scan position is not one-hot");

  // A shown item always enables exactly one digit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot(out_tdata[10:8]))
    else $error("digit select is not one-hot");

  // An executed scan tick moves the scan to the next digit.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_op == OP_SCAN) |=> (scan_pos_r != $past(scan_pos_r)))
    else $error("scan tick did not advance the scan position");

  // An out-of-range number leaves dashes on all digits.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_op == OP_LOAD && s1_num > NUMBER_MAX) |=>
    (pat_r[0] == DASH_PATTERN && pat_r[1] == DASH_PATTERN && pat_r[2] == DASH_PATTERN))
    else $error("overflow load did not show dashes");

endmodule
